>>> rtl/cc2pb_pkg.sv
// ----------------------------------------------------------------------------
// cc2pb_pkg
// Shared types, direction codes and coordinate helpers for the chain code
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cc2pb_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int CODE_BITS  = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [FIELD_BITS-1:0] field_t;
  typedef logic        [CODE_BITS-1:0]  code_t;

  localparam coord_t CRD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CRD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // request kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // direction codes, y grows downward
  localparam code_t DIR_RIGHT      = code_t'(1);
  localparam code_t DIR_UP_RIGHT   = code_t'(2);
  localparam code_t DIR_UP         = code_t'(3);
  localparam code_t DIR_UP_LEFT    = code_t'(4);
  localparam code_t DIR_LEFT       = code_t'(5);
  localparam code_t DIR_DOWN_LEFT  = code_t'(6);
  localparam code_t DIR_DOWN       = code_t'(7);
  localparam code_t DIR_DOWN_RIGHT = code_t'(8);

  typedef struct packed {
    logic   kind;
    field_t start_x;
    field_t start_y;
    code_t  code;
    logic   last;
  } in_item_t;

  typedef struct packed {
    field_t point_x;
    field_t point_y;
    field_t box_left;
    field_t box_right;
    field_t box_top;
    field_t box_bottom;
    logic   chain_end;
  } out_item_t;

  // current point and running box
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
  } trace_t;

  localparam int WIDE_BITS = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;

  // start coordinate into the coordinate range, saturating when narrower
  function automatic coord_t from_field(field_t v);
    logic signed [WIDE_BITS-1:0] wide;
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    wide = WIDE_BITS'(v);
    hi   = WIDE_BITS'(CRD_MAX);
    lo   = WIDE_BITS'(CRD_MIN);
    if (wide > hi) begin
      return CRD_MAX;
    end else if (wide < lo) begin
      return CRD_MIN;
    end
    return COORD_BITS'(wide);
  endfunction

  // low field bits of a coordinate, sign extended when narrower
  function automatic field_t to_field(coord_t c);
    logic signed [WIDE_BITS-1:0] wide;
    wide = WIDE_BITS'(c);
    return wide[FIELD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/cc2pb_step.sv
// ----------------------------------------------------------------------------
// cc2pb_step
// Next point and bounding box for one request: start load or one
// saturating pixel step, then min/max update.
// ----------------------------------------------------------------------------
`default_nettype none

module cc2pb_step
  import cc2pb_pkg::*;
(
  input  var in_item_t item,
  input  var trace_t   st,
  output trace_t       st_nxt
);

  logic   inc_x, dec_x, inc_y, dec_y;
  coord_t x_step, y_step;
  coord_t x0, y0;

  always_comb begin
    inc_x = 1'b0;
    dec_x = 1'b0;
    inc_y = 1'b0;
    dec_y = 1'b0;
    case (item.code)
      DIR_RIGHT: begin
        inc_x = 1'b1;
      end
      DIR_UP_RIGHT: begin
        inc_x = 1'b1;
        dec_y = 1'b1;
      end
      DIR_UP: begin
        dec_y = 1'b1;
      end
      DIR_UP_LEFT: begin
        dec_x = 1'b1;
        dec_y = 1'b1;
      end
      DIR_LEFT: begin
        dec_x = 1'b1;
      end
      DIR_DOWN_LEFT: begin
        dec_x = 1'b1;
        inc_y = 1'b1;
      end
      DIR_DOWN: begin
        inc_y = 1'b1;
      end
      DIR_DOWN_RIGHT: begin
        inc_x = 1'b1;
        inc_y = 1'b1;
      end
      default: ;
    endcase
  end

  // saturate at the range ends by holding the point
  always_comb begin
    x_step = st.cur_x;
    if (inc_x && st.cur_x != CRD_MAX) begin
      x_step = st.cur_x + coord_t'(1);
    end else if (dec_x && st.cur_x != CRD_MIN) begin
      x_step = st.cur_x - coord_t'(1);
    end
    y_step = st.cur_y;
    if (inc_y && st.cur_y != CRD_MAX) begin
      y_step = st.cur_y + coord_t'(1);
    end else if (dec_y && st.cur_y != CRD_MIN) begin
      y_step = st.cur_y - coord_t'(1);
    end
  end

  assign x0 = from_field(item.start_x);
  assign y0 = from_field(item.start_y);

  always_comb begin
    if (item.kind == KIND_START) begin
      st_nxt.cur_x = x0;
      st_nxt.cur_y = y0;
      st_nxt.min_x = x0;
      st_nxt.max_x = x0;
      st_nxt.min_y = y0;
      st_nxt.max_y = y0;
    end else begin
      st_nxt.cur_x = x_step;
      st_nxt.cur_y = y_step;
      st_nxt.min_x = (x_step < st.min_x) ? x_step : st.min_x;
      st_nxt.max_x = (x_step > st.max_x) ? x_step : st.max_x;
      st_nxt.min_y = (y_step < st.min_y) ? y_step : st.min_y;
      st_nxt.max_y = (y_step > st.max_y) ? y_step : st.max_y;
    end
  end

endmodule

`default_nettype wire

>>> rtl/chain_code_to_points_bbox.sv
// ----------------------------------------------------------------------------
// chain_code_to_points_bbox
// Freeman 8-connected chain code decoder with running bounding box.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item): a start request (kind 0)
//   loads the start point and collapses the box onto it; a step request
//   (kind 1) moves the point one pixel by its code 1..8, y growing down.
//   Other codes repeat the point. Coordinates saturate at the signed range.
//   Output channel (out_valid / out_stall / out_item): one result per
//   request with the point, the box so far and chain_end = last.
//   An accepted request is loaded into the input register; its step/min/max
//   result is then loaded into the result register, which drives out_valid.
//   One request per cycle is sustained while out_stall is low; the point/box
//   registers update as each request moves into the result register, so
//   back-to-back requests see each other's state.
//   When out_stall holds a result, one more request is taken into the input
//   register, then in_stall rises until the result is taken.
//   Reset (rst_n low, synchronous) empties both stages and sets point and
//   box to (0,0), so steps before any start continue from the origin.
// ----------------------------------------------------------------------------
`default_nettype none

module chain_code_to_points_bbox
  import cc2pb_pkg::*;
(
  input  var logic      clk,
  input  var logic      rst_n,
  input  var logic      in_valid,
  output logic          in_stall,
  input  var in_item_t  in_item,
  output logic          out_valid,
  input  var logic      out_stall,
  output out_item_t     out_item
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  trace_t    st_r;
  trace_t    st_nxt;
  logic      out_adv;
  logic      s1_adv;
  logic      in_acc;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  cc2pb_step u_step (
    .item   (s1_item_r),
    .st     (st_r),
    .st_nxt (st_nxt)
  );

  always_comb begin
    out_item_nxt.point_x    = to_field(st_nxt.cur_x);
    out_item_nxt.point_y    = to_field(st_nxt.cur_y);
    out_item_nxt.box_left   = to_field(st_nxt.min_x);
    out_item_nxt.box_right  = to_field(st_nxt.max_x);
    out_item_nxt.box_top    = to_field(st_nxt.min_y);
    out_item_nxt.box_bottom = to_field(st_nxt.max_y);
    out_item_nxt.chain_end  = s1_item_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> rtl/cc2pb_checker.sv
// ----------------------------------------------------------------------------
// cc2pb_checker
// Port-level checks for the chain code decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cc2pb_checker
  import cc2pb_pkg::*;
(
  input var logic      clk,
  input var logic      rst_n,
  input var logic      in_valid,
  input var logic      in_stall,
  input var in_item_t  in_item,
  input var logic      out_valid,
  input var logic      out_stall,
  input var out_item_t out_item
);

  // a stalled request keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("request changed while stalled");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // the reported point always lies inside the reported box
  a_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.box_left <= out_item.point_x) &&
                  (out_item.point_x <= out_item.box_right) &&
                  (out_item.box_top <= out_item.point_y) &&
                  (out_item.point_y <= out_item.box_bottom))
    else $error("point outside bounding box");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with nothing pending downstream the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

endmodule

bind chain_code_to_points_bbox cc2pb_checker u_cc2pb_checker (.*);

`default_nettype wire
